### design/cht_pkg.sv
// package: request and response words, operation codes and hash constants
`default_nettype none

package cht_pkg;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // key hash is 28*x + 7*y
  localparam int unsigned HASH_X_MUL = 28;
  localparam int unsigned HASH_Y_MUL = 7;
  // largest magnitude of the hash sum over all keys
  localparam int unsigned HASH_SPAN  = (HASH_X_MUL + HASH_Y_MUL) * 32768;
  localparam int unsigned HASH_SUM_W = 23;
  localparam int unsigned HASH_U_W   = 22;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] key_x;
    logic signed [15:0] key_y;
    logic [15:0]        value_handle;
  } cht_req_t;

  typedef struct packed {
    logic        found;
    logic [15:0] value_out;
    logic        bucket_full;
  } cht_rsp_t;

endpackage

`default_nettype wire

### design/cht_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module cht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/coordinate_hash_table_core.sv
// top level: bucketed coordinate hash table, one bucket row per memory word
//
//  channel | direction | handshake                | word
//  --------+-----------+--------------------------+-----------------------
//  req     | in        | req_valid_i, req_stall_o | cht_req_t req_i
//  rsp     | out       | rsp_valid_o, rsp_stall_i | cht_rsp_t rsp_o
//
// a request passes through hash sum, reciprocal multiply, remainder,
// bucket row read, then compare, update and row write back in the same cycle.
// the next request can be taken in the cycle after the update.
// after reset a clearing pass writes every bucket row and zeroes every bucket fill.
// a stalled response holds the update cycle until the output word is free.
`default_nettype none

module coordinate_hash_table_core #(
  parameter int unsigned BUCKETS      = 10,
  parameter int unsigned BUCKET_DEPTH = 8,
  parameter int unsigned HANDLE_BITS  = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  input  wire cht_pkg::cht_req_t req_i,
  output logic                   req_stall_o,
  output logic                   rsp_valid_o,
  output cht_pkg::cht_rsp_t      rsp_o,
  input  wire logic              rsp_stall_i
);
  import cht_pkg::*;

  localparam int unsigned BW   = $clog2(BUCKETS);
  localparam int unsigned FW   = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned SW   = 32 + HANDLE_BITS;
  localparam int unsigned RW   = BUCKET_DEPTH * SW + FW;
  localparam int unsigned HASH_K      = (HASH_SPAN + BUCKETS - 1) / BUCKETS;
  localparam int unsigned HASH_OFFSET = HASH_K * BUCKETS;
  localparam logic [31:0] RECIP =
    32'(((64'd1 << 32) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_REM  = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;

  typedef struct packed {
    logic [15:0]            kx;
    logic [15:0]            ky;
    logic [HANDLE_BITS-1:0] handle;
  } cht_slot_t;

  logic [2:0]          state_q, state_d;
  logic [BW-1:0]       clr_q, clr_d;
  cht_req_t            req_q, req_d;
  logic [HASH_U_W-1:0] u_q, u_d;
  logic [HASH_U_W-1:0] quot_q, quot_d;
  logic [BW-1:0]       bucket_q, bucket_d;
  logic                rsp_valid_q, rsp_valid_d;
  cht_rsp_t            rsp_q, rsp_d;

  logic                ram_we, ram_re;
  logic [BW-1:0]       ram_waddr;
  logic [RW-1:0]       ram_wdata, ram_rdata;

  logic signed [HASH_SUM_W-1:0] sx, sy, hsum;
  logic [HASH_U_W+32-1:0]       prod;
  logic [32:0]                  qb;
  logic [HASH_U_W-1:0]          rem_raw, rem_fix;

  cht_slot_t              slot_rd [BUCKET_DEPTH];
  cht_slot_t              slot_wr [BUCKET_DEPTH];
  cht_slot_t              ins_slot;
  logic [FW-1:0]          fill_rd, fill_wr;
  logic [FW-1:0]          hit_idx;
  logic                   hit;
  logic [HANDLE_BITS-1:0] hit_handle;
  logic [31:0]            hit_wide;
  logic [31:0]            handle_in;
  logic                   out_free;

  cht_ram #(
    .WIDTH (RW),
    .DEPTH (BUCKETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (bucket_q),
    .rdata_o (ram_rdata)
  );

  // hash sum shifted to a non-negative value with the same remainder
  always_comb begin
    sx   = HASH_SUM_W'(req_i.key_x);
    sy   = HASH_SUM_W'(req_i.key_y);
    hsum = (sx <<< 5) - (sx <<< 2) + (sy <<< 3) - sy + HASH_SUM_W'(HASH_OFFSET);
    u_d  = hsum[HASH_U_W-1:0];
  end

  always_comb begin
    prod    = (HASH_U_W + 32)'(u_q) * (HASH_U_W + 32)'(RECIP);
    quot_d  = prod[HASH_U_W+32-1:32];
    qb      = 33'(quot_q) * 33'(BUCKETS);
    rem_raw = u_q - qb[HASH_U_W-1:0];
    rem_fix = (rem_raw >= HASH_U_W'(BUCKETS)) ? rem_raw - HASH_U_W'(BUCKETS) : rem_raw;
    bucket_d = rem_fix[BW-1:0];
  end

  // bucket row unpack and newest-match search
  always_comb begin
    fill_rd    = ram_rdata[BUCKET_DEPTH*SW +: FW];
    hit        = 1'b0;
    hit_idx    = '0;
    for (int i = 0; i < BUCKET_DEPTH; i++) begin
      slot_rd[i] = ram_rdata[i*SW +: SW];
      if ((FW'(i) < fill_rd) && (slot_rd[i].kx == req_q.key_x) &&
          (slot_rd[i].ky == req_q.key_y)) begin
        hit     = 1'b1;
        hit_idx = FW'(i);
      end
    end
    hit_handle = '0;
    for (int i = 0; i < BUCKET_DEPTH; i++) begin
      if (FW'(i) == hit_idx) begin
        hit_handle = slot_rd[i].handle;
      end
    end
    hit_wide  = 32'(hit_handle);
    handle_in = 32'(req_q.value_handle);
    ins_slot.kx     = req_q.key_x;
    ins_slot.ky     = req_q.key_y;
    ins_slot.handle = handle_in[HANDLE_BITS-1:0];
  end

  // row update for insert and remove
  always_comb begin
    fill_wr = fill_rd;
    for (int i = 0; i < BUCKET_DEPTH; i++) begin
      slot_wr[i] = slot_rd[i];
    end
    case (req_q.operation)
      OP_INSERT: begin
        fill_wr = fill_rd + FW'(1);
        for (int i = 0; i < BUCKET_DEPTH; i++) begin
          if (FW'(i) == fill_rd) begin
            slot_wr[i] = ins_slot;
          end
        end
      end
      OP_REMOVE: begin
        fill_wr = fill_rd - FW'(1);
        for (int i = 0; i < BUCKET_DEPTH - 1; i++) begin
          if (FW'(i) >= hit_idx) begin
            slot_wr[i] = slot_rd[i+1];
          end
        end
      end
      default: begin
        fill_wr = fill_rd;
      end
    endcase
  end

  assign out_free = !rsp_valid_q || !rsp_stall_i;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    req_d       = req_q;
    rsp_valid_d = rsp_valid_q && rsp_stall_i;
    rsp_d       = rsp_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = bucket_q;
    ram_wdata   = '0;
    case (state_q)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + BW'(1);
        if (clr_q == BW'(BUCKETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          req_d   = req_i;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_REM;
      end
      ST_REM: begin
        state_d = ST_RD;
      end
      ST_RD: begin
        ram_re  = 1'b1;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        for (int i = 0; i < BUCKET_DEPTH; i++) begin
          ram_wdata[i*SW +: SW] = slot_wr[i];
        end
        ram_wdata[BUCKET_DEPTH*SW +: FW] = fill_wr;
        if (out_free) begin
          rsp_valid_d       = 1'b1;
          rsp_d.found       = 1'b0;
          rsp_d.value_out   = '0;
          rsp_d.bucket_full = 1'b0;
          case (req_q.operation)
            OP_LOOKUP: begin
              rsp_d.found     = hit;
              rsp_d.value_out = hit ? hit_wide[15:0] : 16'd0;
            end
            OP_INSERT: begin
              if (fill_rd >= FW'(BUCKET_DEPTH)) begin
                rsp_d.bucket_full = 1'b1;
              end else begin
                ram_we = 1'b1;
              end
            end
            OP_REMOVE: begin
              rsp_d.found = hit;
              ram_we      = hit;
            end
            default: begin
              rsp_d.found = 1'b0;
            end
          endcase
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    rsp_q    <= rsp_d;
    if (state_q == ST_IDLE) begin
      u_q <= u_d;
    end
    if (state_q == ST_MUL) begin
      quot_q <= quot_d;
    end
    if (state_q == ST_REM) begin
      bucket_q <= bucket_d;
    end
  end

  assign req_stall_o = (state_q != ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTHESIS
  a_rsp_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_o) |-> $past(state_q) == ST_UPD)
    else $error("response word raised outside the update cycle");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLR || state_q == ST_UPD))
    else $error("row write outside clearing or update");

  a_bucket_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD |-> {1'b0, bucket_q} < (BW + 1)'(BUCKETS))
    else $error("bucket index out of range");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |-> fill_rd <= FW'(BUCKET_DEPTH))
    else $error("bucket fill beyond depth");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !(rsp_o.found && rsp_o.bucket_full))
    else $error("found and bucket full both set");
`endif

endmodule

`default_nettype wire

### bench/cht_checker.sv
// checker: watches both channels, predicts each response word and compares it
module cht_checker #(
  parameter int BUCKETS      = 10,
  parameter int BUCKET_DEPTH = 8,
  parameter int HANDLE_BITS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_stall_i,
  input  cht_pkg::cht_req_t req_i,
  input  logic              rsp_valid_i,
  input  logic              rsp_stall_i,
  input  cht_pkg::cht_rsp_t rsp_i,
  output int                fail_count_o,
  output int                outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import cht_pkg::*;

  localparam logic [15:0] HANDLE_MASK =
    (HANDLE_BITS >= 16) ? 16'hFFFF : 16'((1 << HANDLE_BITS) - 1);

  logic [15:0] slot_x [BUCKETS][BUCKET_DEPTH];
  logic [15:0] slot_y [BUCKETS][BUCKET_DEPTH];
  logic [15:0] slot_h [BUCKETS][BUCKET_DEPTH];
  int          fill   [BUCKETS];
  cht_rsp_t    expected_rsp_q [$];
  int          fails;

  function automatic int bucket_index(logic signed [15:0] kx, logic signed [15:0] ky);
    int sum;
    int rem;
    sum = int'(HASH_X_MUL) * int'(kx) + int'(HASH_Y_MUL) * int'(ky);
    rem = sum % BUCKETS;
    if (rem < 0) rem += BUCKETS;
    return rem;
  endfunction

  function automatic int newest_match(int b, logic [15:0] kx, logic [15:0] ky);
    for (int i = fill[b] - 1; i >= 0; i--) begin
      if (slot_x[b][i] == kx && slot_y[b][i] == ky) return i;
    end
    return -1;
  endfunction

  function automatic cht_rsp_t predict_response(cht_req_t w);
    cht_rsp_t r;
    int b;
    int n;
    int hit;
    r = '0;
    b = bucket_index(w.key_x, w.key_y);
    n = fill[b];
    case (w.operation)
      OP_LOOKUP: begin
        hit = newest_match(b, w.key_x, w.key_y);
        if (hit >= 0) begin
          r.found     = 1'b1;
          r.value_out = slot_h[b][hit];
        end
      end
      OP_INSERT: begin
        if (n >= BUCKET_DEPTH) begin
          r.bucket_full = 1'b1;
        end else begin
          slot_x[b][n] = w.key_x;
          slot_y[b][n] = w.key_y;
          slot_h[b][n] = w.value_handle & HANDLE_MASK;
          fill[b]      = n + 1;
        end
      end
      OP_REMOVE: begin
        hit = newest_match(b, w.key_x, w.key_y);
        if (hit >= 0) begin
          r.found = 1'b1;
          for (int i = hit; i < n - 1; i++) begin
            slot_x[b][i] = slot_x[b][i+1];
            slot_y[b][i] = slot_y[b][i+1];
            slot_h[b][i] = slot_h[b][i+1];
          end
          fill[b] = n - 1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cht_rsp_t want;
    if (!rst_ni) begin
      for (int b = 0; b < BUCKETS; b++) fill[b] = 0;
      expected_rsp_q.delete();
      fails = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (rsp_valid_i && !rsp_stall_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response word with no request waiting");
          fails++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_i.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, rsp_i.found);
            fails++;
          end
          if (rsp_i.value_out !== want.value_out) begin
            $error("value_out: expected %0h, got %0h", want.value_out, rsp_i.value_out);
            fails++;
          end
          if (rsp_i.bucket_full !== want.bucket_full) begin
            $error("bucket_full: expected %0d, got %0d", want.bucket_full,
                   rsp_i.bucket_full);
            fails++;
          end
        end
      end
      if (req_valid_i && !req_stall_i) expected_rsp_q.push_back(predict_response(req_i));
      fail_count_o  <= fails;
      outstanding_o <= expected_rsp_q.size();
    end
  end

endmodule

### bench/tb_coordinate_hash_table_core.sv
// testbench top: request stimulus, response stall pattern and verdict
module tb_coordinate_hash_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cht_pkg::*;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int POOL_SIZE    = 24;
  localparam int RANDOM_WORDS = 900;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_e;

  logic     clk_i       = 1'b0;
  logic     rst_n       = 1'b0;
  logic     req_valid   = 1'b0;
  cht_req_t req_word    = '0;
  logic     rsp_stall   = 1'b0;
  logic     req_stall_o;
  logic     rsp_valid_o;
  cht_rsp_t rsp_o;
  int       fail_count;
  int       outstanding;

  int          burst_left = 0;
  logic [15:0] pool_x [POOL_SIZE];
  logic [15:0] pool_y [POOL_SIZE];

  coordinate_hash_table_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .req_valid_i (req_valid),
    .req_i       (req_word),
    .req_stall_o (req_stall_o),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .rsp_stall_i (rsp_stall)
  );

  cht_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .req_valid_i   (req_valid),
    .req_stall_i   (req_stall_o),
    .req_i         (req_word),
    .rsp_valid_i   (rsp_valid_o),
    .rsp_stall_i   (rsp_stall),
    .rsp_i         (rsp_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    stall_mode_e mode;
    int          left;
    int          run;
    logic        run_level;
    mode      = STALL_NONE;
    left      = 0;
    run       = 0;
    run_level = 1'b0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = stall_mode_e'($urandom_range(0, 2));
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        STALL_NONE:   rsp_stall <= 1'b0;
        STALL_RANDOM: rsp_stall <= ($urandom_range(0, 99) < 35);
        default: begin
          if (run == 0) begin
            run       = $urandom_range(1, 12);
            run_level = ~run_level;
          end
          run--;
          rsp_stall <= run_level;
        end
      endcase
    end
  end

  task automatic send_word(logic [1:0] op, logic [15:0] kx, logic [15:0] ky,
                           logic [15:0] h);
    cht_req_t w;
    int gap;
    w.operation    = op;
    w.key_x        = kx;
    w.key_y        = ky;
    w.value_handle = h;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    req_valid <= 1'b1;
    req_word  <= w;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
  endtask

  task automatic pick_key(output logic [15:0] kx, output logic [15:0] ky);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      sel = $urandom_range(0, POOL_SIZE - 1);
      kx  = pool_x[sel];
      ky  = pool_y[sel];
    end else if (sel < 85) begin
      kx = 16'($urandom_range(0, 16)) - 16'd8;
      ky = 16'($urandom_range(0, 16)) - 16'd8;
    end else begin
      kx = 16'($urandom_range(0, 65535));
      ky = 16'($urandom_range(0, 65535));
    end
  endtask

  function automatic logic [1:0] pick_op(bit fill_phase);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return OP_RESERVED;
    if (fill_phase) begin
      if (sel < 55) return OP_INSERT;
      if (sel < 80) return OP_LOOKUP;
      return OP_REMOVE;
    end
    if (sel < 20) return OP_INSERT;
    if (sel < 55) return OP_LOOKUP;
    return OP_REMOVE;
  endfunction

  initial begin
    logic [15:0] kx;
    logic [15:0] ky;
    logic [1:0]  op;
    pool_x[0] = 16'h7FFF; pool_y[0] = 16'h7FFF;
    pool_x[1] = 16'h8000; pool_y[1] = 16'h8000;
    pool_x[2] = 16'h7FFF; pool_y[2] = 16'h8000;
    pool_x[3] = 16'hFFFF; pool_y[3] = 16'hFFFF;
    for (int i = 4; i < POOL_SIZE; i++) begin
      if (i % 3 == 0) begin
        pool_x[i] = 16'($urandom_range(0, 65535));
        pool_y[i] = 16'($urandom_range(0, 65535));
      end else begin
        pool_x[i] = 16'($urandom_range(0, 20)) - 16'd10;
        pool_y[i] = 16'($urandom_range(0, 20)) - 16'd10;
      end
    end

    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // empty table, unused code, extremes
    send_word(OP_LOOKUP,   16'h0000, 16'h0000, 16'h5555);
    send_word(OP_REMOVE,   16'h0000, 16'h0000, 16'hAAAA);
    send_word(OP_RESERVED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(OP_INSERT,   16'h7FFF, 16'h7FFF, 16'hFFFF);
    send_word(OP_INSERT,   16'h8000, 16'h8000, 16'h0000);
    send_word(OP_LOOKUP,   16'h7FFF, 16'h7FFF, 16'h0000);
    send_word(OP_LOOKUP,   16'h8000, 16'h8000, 16'hFFFF);
    // negative hash sum, duplicate keys shadowing
    send_word(OP_INSERT,   16'hFFFF, 16'h0000, 16'h1234);
    send_word(OP_INSERT,   16'hFFFF, 16'h0000, 16'hABCD);
    send_word(OP_LOOKUP,   16'hFFFF, 16'h0000, 16'h0000);
    send_word(OP_REMOVE,   16'hFFFF, 16'h0000, 16'h0000);
    send_word(OP_LOOKUP,   16'hFFFF, 16'h0000, 16'h0000);
    // fill one bucket past its depth
    for (int k = 0; k < 9; k++)
      send_word(OP_INSERT, 16'h0000, 16'(10 * k), 16'(16'h0100 + k));
    // oldest entry, then a middle one
    send_word(OP_REMOVE,   16'h0000, 16'd0,  16'h0000);
    send_word(OP_LOOKUP,   16'h0000, 16'd10, 16'h0000);
    send_word(OP_REMOVE,   16'h0000, 16'd40, 16'h0000);
    send_word(OP_LOOKUP,   16'h0000, 16'd70, 16'h0000);
    send_word(OP_LOOKUP,   16'h0000, 16'd80, 16'h0000);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      op = pick_op(((n / 120) % 2) == 0);
      pick_key(kx, ky);
      send_word(op, kx, ky, 16'($urandom_range(0, 65535)));
    end
    req_valid <= 1'b0;

    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
